// File: sv/isa_pkg.sv
// Shared types and constants of the impedance sweep accumulator.
// Used by the controller, the datapath and the top level. No dependencies.
package isa_pkg;

  localparam int POINTS     = 16;
  localparam int POINTS_W   = $clog2(POINTS + 1);
  localparam int PART_W     = 16;
  localparam int GAIN_W     = 31;
  localparam int SUM_W      = 31;
  localparam int PROD_W     = GAIN_W + POINTS_W;
  localparam int SQ_W       = 2 * PART_W;
  localparam int MAG_W      = SQ_W / 2;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int CNT_W      = $clog2(PROD_W);
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_ROOT,
    ST_DIV_PREP,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } isa_state_e;

  typedef struct packed {
    logic load;
    logic sq_re;
    logic sq_im;
    logic root_step;
    logic div_init;
    logic div_step;
    logic acc;
    logic emit;
  } isa_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic mag_zero;
    logic last;
    logic out_free;
  } isa_status_t;

endpackage

// File: sv/isa_ctrl.sv
// Sequencing state machine of the impedance sweep accumulator.
// Depends on isa_pkg for the state type and the command and status structs.
module isa_ctrl
  import isa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  isa_status_t status_i,
  output isa_cmd_t    cmd_o
);

  isa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SQ_RE;
      end
      ST_SQ_RE: state_d = ST_SQ_IM;
      ST_SQ_IM: state_d = ST_ROOT;
      ST_ROOT: begin
        if (status_i.cnt_zero) state_d = ST_DIV_PREP;
      end
      ST_DIV_PREP: begin
        state_d = status_i.mag_zero ? ST_ACC : ST_DIV;
      end
      ST_DIV: begin
        if (status_i.cnt_zero) state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = status_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SQ_RE:    cmd_o.sq_re     = 1'b1;
      ST_SQ_IM:    cmd_o.sq_im     = 1'b1;
      ST_ROOT:     cmd_o.root_step = 1'b1;
      ST_DIV_PREP: cmd_o.div_init  = 1'b1;
      ST_DIV:      cmd_o.div_step  = 1'b1;
      ST_ACC:      cmd_o.acc       = 1'b1;
      ST_EMIT:     cmd_o.emit      = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/isa_datapath.sv
// Datapath of the impedance sweep accumulator: shared squarer, iterative
// root, restoring divider, saturating sum and output register. Uses isa_pkg.
module isa_datapath
  import isa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isa_cmd_t            cmd_i,
  output isa_status_t         status_o,
  input  logic [PART_W-1:0]   real_part_i,
  input  logic [PART_W-1:0]   imag_part_i,
  input  logic [GAIN_W-1:0]   gain_inverse_i,
  input  logic                last_point_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [SUM_W-1:0]    impedance_sum_o,
  output logic                saturated_o
);

  logic [PART_W-1:0] re_q, im_q;
  logic              last_q;
  logic [SQ_W-1:0]   v_q, res_q, bit_q;
  logic [PROD_W-1:0] quot_q;
  logic [MAG_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  acc_q;
  logic              ovf_q;
  logic              out_valid_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic              out_sat_q;

  // One signed squarer, shared by the real and the imaginary part.
  logic signed [PART_W-1:0] sq_op;
  logic signed [SQ_W-1:0]   sq_prod;
  assign sq_op   = cmd_i.sq_re ? $signed(re_q) : $signed(im_q);
  assign sq_prod = sq_op * sq_op;

  logic [PROD_W-1:0] gain_prod;
  assign gain_prod = PROD_W'(gain_inverse_i) * PROD_W'(POINTS);

  logic [SQ_W:0] trial;
  logic          trial_ok;
  assign trial    = {1'b0, res_q} + {1'b0, bit_q};
  assign trial_ok = {1'b0, v_q} >= trial;

  logic [MAG_W-1:0] mag;
  logic [MAG_W:0]   rem_sh;
  logic             div_ok;
  assign mag    = res_q[MAG_W-1:0];
  assign rem_sh = {rem_q, quot_q[PROD_W-1]};
  assign div_ok = rem_sh >= {1'b0, mag};

  logic [PROD_W:0] sum_wide;
  assign sum_wide = (PROD_W + 1)'(acc_q) + {1'b0, quot_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      re_q   <= real_part_i;
      im_q   <= imag_part_i;
      last_q <= last_point_i;
      quot_q <= gain_prod;
    end
    if (cmd_i.sq_re) v_q <= SQ_W'(sq_prod);
    if (cmd_i.sq_im) begin
      v_q   <= v_q + SQ_W'(sq_prod);
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end
    if (cmd_i.root_step) begin
      if (trial_ok) begin
        v_q   <= v_q - trial[SQ_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) rem_q <= '0;
    if (cmd_i.div_step) begin
      if (div_ok) begin
        rem_q <= MAG_W'(rem_sh - {1'b0, mag});
      end else begin
        rem_q <= rem_sh[MAG_W-1:0];
      end
      quot_q <= {quot_q[PROD_W-2:0], div_ok};
    end
    if (cmd_i.emit) begin
      out_sum_q <= acc_q;
      out_sat_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sq_im) begin
        cnt_q <= CNT_W'(ROOT_STEPS - 1);
      end else if (cmd_i.div_init) begin
        cnt_q <= CNT_W'(PROD_W - 1);
      end else if (cmd_i.root_step || cmd_i.div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.acc && (mag != '0)) begin
        if (sum_wide > (PROD_W + 1)'(SUM_MAX)) begin
          acc_q <= SUM_MAX;
          ovf_q <= 1'b1;
        end else begin
          acc_q <= sum_wide[SUM_W-1:0];
        end
      end
      if (cmd_i.emit) begin
        acc_q       <= '0;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.mag_zero = (mag == '0);
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign impedance_sum_o = out_sum_q;
  assign saturated_o     = out_sat_q;

endmodule

// File: sv/impedance_sweep_accumulator_top.sv
// Top level of the impedance sweep accumulator.
// Instantiates isa_ctrl and isa_datapath; uses isa_pkg.

// The block takes one frequency point of an impedance sweep per item and
// accumulates floor(gain_inverse * 16 / |z|) over the sweep, where |z| is the
// floor square root of real^2 + imag^2. Points of zero magnitude add nothing.
// On the item whose tlast is set, the sum goes out as one result item, clamped
// to 2^31-1, with tuser set when clamping happened anywhere in that sweep; the
// sum and the flag then start again from zero. Items are taken one at a time.
// Per point, the controller steps from idle through the shared squarer (real
// part, then imaginary part), sixteen iterations of the two-bit-per-step
// root, a divider setup state, PROD_W iterations of the one-bit-per-step
// restoring divider and an accumulate state. A zero magnitude skips the
// divider, and the last point of a sweep also passes an emit state that loads
// the output register, waiting there while a previous result is still held.
// A waiting result does not stop the next items of a sweep from being
// accepted.
module impedance_sweep_accumulator_top
  import isa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input item, tdata from bit 0 up: real_part[15:0], imag_part[15:0],
  // gain_inverse[30:0], one zero pad bit.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // Marks the last point of a sweep (last_point).
  input  logic                  s_axis_tlast_i,
  // Result item, tdata from bit 0 up: impedance_sum[30:0], one zero pad bit.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: saturated, set when the sum was clamped.
  output logic                  m_axis_tuser_o
);

  isa_cmd_t         cmd;
  isa_status_t      status;
  logic [SUM_W-1:0] impedance_sum;

  isa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  isa_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .real_part_i     (s_axis_tdata_i[PART_W-1:0]),
    .imag_part_i     (s_axis_tdata_i[2*PART_W-1:PART_W]),
    .gain_inverse_i  (s_axis_tdata_i[2*PART_W+GAIN_W-1:2*PART_W]),
    .last_point_i    (s_axis_tlast_i),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .impedance_sum_o (impedance_sum),
    .saturated_o     (m_axis_tuser_o)
  );

  // The sum sits in the low bits; the pad bit above it is zero.
  assign m_axis_tdata_o = OUT_DATA_W'(impedance_sum);

endmodule

// File: sv/isa_checker.sv
// Port-level assertions for the impedance sweep accumulator, bound to the
// top level. Uses isa_pkg for widths and the saturation limit.
module isa_checker
  import isa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                  s_axis_tlast_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tuser_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Points are worked on one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a point is in work");

  // A new result appears only while a point is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a point in work");

  // A clamped sum always shows the saturation limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[SUM_W-1:0] == SUM_MAX && !m_axis_tdata_o[OUT_DATA_W-1])
    else $error("saturated result is not at the limit");

endmodule

bind impedance_sweep_accumulator_top isa_checker u_isa_checker (.*);

// File: verif/impedance_sweep_accumulator_top_test.sv
// Self-checking testbench of impedance_sweep_accumulator_top: sweeps of points go in on the
// input stream, and each sweep sum that comes out is checked against a local predictor.
// Depends on isa_pkg and the RTL of the block only.
module impedance_sweep_accumulator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import isa_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 150;
  localparam int REPORT_MAX    = 10;

  // Magnitude classes used to steer random points toward small roots,
  // where the terms become large and the sum clamps.
  typedef enum int {PART_ZERO, PART_TINY, PART_MEDIUM, PART_FULL} part_kind_e;
  typedef enum int {GAIN_NONE, GAIN_LOW, GAIN_ANY, GAIN_TOP} gain_kind_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             sat;
  } sweep_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  // Predictor state: the sum of the sweep in progress and its clamp flag.
  logic [SUM_W-1:0] sweep_total;
  logic             sweep_clamped;
  sweep_result_t    sweep_results_q[$];

  int  mismatch_count;
  int  cycle_count;
  int  points_sent;
  bit  tx_steady;
  bit  rx_steady;
  int  rx_hold;
  bit  rx_took;

  impedance_sweep_accumulator_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Floor square root, built bit by bit from the top: keep a bit when the
  // square of the candidate still fits under the operand.
  function automatic logic [16:0] floor_root(input logic [31:0] operand);
    logic [16:0]     root;
    logic [16:0]     trial;
    longint unsigned trial_sq;
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial    = root | (17'd1 << b);
      trial_sq = longint'(trial) * longint'(trial);
      if (trial_sq <= longint'(operand)) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Adds one point to the sweep in progress and, on the last point, queues
  // the sweep result and starts a new sweep.
  task automatic accumulate_point(input logic signed [PART_W-1:0] re,
                                  input logic signed [PART_W-1:0] im,
                                  input logic [GAIN_W-1:0] gain, input logic last);
    longint      re_w;
    longint      im_w;
    logic [31:0] energy;
    logic [16:0] mag;
    logic [35:0] term;
    logic [36:0] total;
    re_w   = re;
    im_w   = im;
    energy = 32'(re_w * re_w + im_w * im_w);
    mag    = floor_root(energy);
    if (mag != 0) begin
      term  = (36'(gain) * 36'(POINTS)) / 36'(mag);
      total = 37'(sweep_total) + 37'(term);
      if (total > 37'(SUM_MAX)) begin
        sweep_total   = SUM_MAX;
        sweep_clamped = 1'b1;
      end else begin
        sweep_total = total[SUM_W-1:0];
      end
    end
    if (last) begin
      sweep_results_q.push_back('{sum: sweep_total, sat: sweep_clamped});
      sweep_total   = '0;
      sweep_clamped = 1'b0;
    end
  endtask

  function automatic int draw_idle(input bit steady);
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // Sends one point. Valid stays high from one item to the next when no gap
  // is drawn, so it is never lowered and raised within one step.
  task automatic send_point(input logic signed [PART_W-1:0] re,
                            input logic signed [PART_W-1:0] im,
                            input logic [GAIN_W-1:0] gain, input logic last);
    int gap;
    gap = draw_idle(tx_steady);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tdata_i  = {1'b0, gain, im, re};
    s_axis_tlast_i  = last;
    s_axis_tvalid_i = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    accumulate_point(re, im, gain, last);
    points_sent++;
  endtask

  // Valid goes low first, so the item just sent is not offered again.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (sweep_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [PART_W-1:0] rand_part(input part_kind_e kind);
    case (kind)
      PART_ZERO:   return '0;
      PART_TINY:   return PART_W'($urandom_range(0, 8) - 4);
      PART_MEDIUM: return PART_W'($urandom_range(0, 600) - 300);
      default:     return PART_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain(input gain_kind_e kind);
    case (kind)
      GAIN_NONE: return '0;
      GAIN_LOW:  return GAIN_W'($urandom_range(0, 1000));
      GAIN_ANY:  return GAIN_W'($urandom);
      default:   return SUM_MAX;
    endcase
  endfunction

  // One random point of a sweep; about one point in eight has zero magnitude.
  task automatic send_random_point(input logic last);
    part_kind_e re_kind;
    part_kind_e im_kind;
    if ($urandom_range(0, 7) == 0) begin
      re_kind = PART_ZERO;
      im_kind = PART_ZERO;
    end else begin
      re_kind = part_kind_e'($urandom_range(PART_TINY, PART_FULL));
      im_kind = part_kind_e'($urandom_range(PART_ZERO, PART_FULL));
    end
    send_point(rand_part(re_kind), rand_part(im_kind),
               rand_gain(gain_kind_e'($urandom_range(GAIN_NONE, GAIN_TOP))), last);
  endtask

  task automatic send_random_sweep(input int length);
    for (int i = 1; i <= length; i++) begin
      send_random_point(i == length);
    end
  endtask

  // Field extremes, zero magnitude on a last point, clamping and its
  // persistence, and alternating bit patterns.
  task automatic test_directed_points();
    send_point(16'sd0, 16'sd0, SUM_MAX, 1'b1);
    send_point(-16'sd32768, -16'sd32768, SUM_MAX, 1'b1);
    send_point(16'sd32767, 16'sd32767, 31'd1, 1'b1);
    send_point(16'sd32767, 16'sd0, 31'd0, 1'b1);
    send_point(-16'sd1, 16'sd1, 31'd1, 1'b1);
    // Magnitude five, then a zero-magnitude last point still emits the sum.
    send_point(16'sd3, 16'sd4, 31'd5, 1'b0);
    send_point(16'sd0, 16'sd0, 31'd12345, 1'b1);
    // A unit magnitude with the top gain overflows at once; later points
    // of the same sweep keep the sum clamped.
    send_point(16'sd1, 16'sd0, SUM_MAX, 1'b0);
    send_point(16'sd0, -16'sd1, 31'd7, 1'b0);
    send_point(16'sd0, 16'sd0, 31'd0, 1'b1);
    // The flag must be clear again in the next sweep.
    send_point(16'sd0, 16'sd2, 31'd100, 1'b1);
    send_point(16'sh5555, -16'sh5556, 31'h5555_5555, 1'b0);
    send_point(-16'sh5556, 16'sh5555, 31'h2aaa_aaaa, 1'b1);
    // Sum just below the clamp, then exactly at it.
    send_point(16'sd16, 16'sd0, 31'h7fff_fffe, 1'b0);
    send_point(16'sd16, 16'sd0, 31'd1, 1'b1);
    send_point(16'sd0, -16'sd32768, 31'h4000_0000, 1'b1);
  endtask

  task automatic test_random_sweeps(input int target);
    int stop_at;
    stop_at = points_sent + target;
    while (points_sent < stop_at) begin
      // Some sweeps run with one or both sides never idling.
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      send_random_sweep($urandom_range(1, 8));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // The sender holds off until every result is out before each sweep.
  task automatic test_pause_until_drained();
    repeat (8) begin
      wait_results_drained();
      send_random_sweep($urandom_range(1, 5));
    end
  endtask

  // Full rate on both sides, so a result can still sit in the output
  // register while the next sweep is accepted.
  task automatic test_full_rate();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (30) begin
      send_random_sweep($urandom_range(1, 4));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result receiver: a stall is drawn after each accepted result.
  always @(negedge clk_i) begin
    if (rx_took) begin
      rx_hold = draw_idle(rx_steady);
      rx_took = 1'b0;
    end
    if (rx_hold > 0) begin
      m_axis_tready_i = 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sweep_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      rx_took = 1'b1;
      if (sweep_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("%0t: unexpected result sum=%0d saturated=%0b", $realtime,
                   m_axis_tdata_o[SUM_W-1:0], m_axis_tuser_o);
        end
      end else begin
        want = sweep_results_q.pop_front();
        if (m_axis_tdata_o[SUM_W-1:0] !== want.sum || m_axis_tuser_o !== want.sat) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: result mismatch: expected sum=%0d saturated=%0b, got sum=%0d saturated=%0b",
                     $realtime, want.sum, want.sat, m_axis_tdata_o[SUM_W-1:0],
                     m_axis_tuser_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    sweep_total     = '0;
    sweep_clamped   = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    points_sent     = 0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    rx_hold         = 0;
    rx_took         = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_points();
    test_random_sweeps(335);
    test_pause_until_drained();
    test_full_rate();

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: impedance_sweep_accumulator_top.f
sv/isa_pkg.sv
sv/isa_ctrl.sv
sv/isa_datapath.sv
sv/impedance_sweep_accumulator_top.sv
sv/isa_checker.sv
verif/impedance_sweep_accumulator_top_test.sv
